// ===== design/ansi_x923_padding_unit_assert.svh =====
// assertion macros for the ansi x9.23 padding unit
`ifndef ANSI_X923_PADDING_UNIT_ASSERT_SVH
`define ANSI_X923_PADDING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define APU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define APU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define APU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define APU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/apu_pkg.sv =====
// shared constants, types and helpers of the padding unit
package apu_pkg;

	localparam int MAX_BLOCK = 32;
	localparam int BLK_W = $clog2(MAX_BLOCK + 1);
	localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int CFG_W = 6;

	// register indexes
	localparam logic CFG_DIRECTION = 1'b0;
	localparam logic CFG_BLOCK_SIZE = 1'b1;

	// direction codes
	localparam logic DIR_ADD = 1'b0;
	localparam logic DIR_REMOVE = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_PAD = 2'd2;

	typedef struct packed {
		logic shift;
		logic load_new;
	} chain_ctl_t;

	// clamp a written block size to 1..MAX_BLOCK
	function automatic logic [BLK_W-1:0] eff_block(input logic [CFG_W-1:0] raw);
		logic [BLK_W-1:0] r;
		begin
			if (raw == '0) begin
				r = BLK_W'(1);
			end else if ({{(32-CFG_W){1'b0}}, raw} > 32'(MAX_BLOCK)) begin
				r = BLK_W'(MAX_BLOCK);
			end else begin
				r = BLK_W'(raw);
			end
			return r;
		end
	endfunction

endpackage

// ===== design/apu_cell.sv =====
// one byte cell of the hold-back delay line
module apu_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [7:0]                  din,
	input  logic [apu_pkg::IDX_W-1:0]   idx,
	input  logic [apu_pkg::IDX_W-1:0]   tail_idx,
	output logic [7:0]                  q,
	output logic [7:0]                  tap
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= din;
		end
	end

	assign q = data_q;
	// only the cell at the end of the active block drives the tail bus
	assign tap = (idx == tail_idx) ? data_q : 8'h00;

endmodule

// ===== design/apu_chain.sv =====
// row of byte cells that shifts or rotates over the active block length
module apu_chain (
	input  logic                        clk,
	input  apu_pkg::chain_ctl_t         ctl,
	input  logic [7:0]                  in_byte,
	input  logic [apu_pkg::IDX_W-1:0]   tail_idx,
	output logic [7:0]                  head,
	output logic [7:0]                  tail
);

	logic [7:0] q   [apu_pkg::MAX_BLOCK];
	logic [7:0] tap [apu_pkg::MAX_BLOCK];
	logic [7:0] tail_w;

	genvar gi;
	generate
		for (gi = 0; gi < apu_pkg::MAX_BLOCK; gi++) begin : g_cell
			logic [7:0] din;
			if (gi == 0) begin : g_first
				assign din = ctl.load_new ? in_byte : tail_w;
			end else begin : g_rest
				assign din = q[gi-1];
			end
			apu_cell u_cell (
				.clk      (clk),
				.en       (ctl.shift),
				.din      (din),
				.idx      (apu_pkg::IDX_W'(gi)),
				.tail_idx (tail_idx),
				.q        (q[gi]),
				.tap      (tap[gi])
			);
		end
	endgenerate

	always_comb begin
		tail_w = 8'h00;
		for (int i = 0; i < apu_pkg::MAX_BLOCK; i++) begin
			tail_w = tail_w | tap[i];
		end
	end

	assign head = q[0];
	assign tail = tail_w;

endmodule

// ===== design/ansi_x923_padding_unit.sv =====
// ansi x9.23 padding unit: adds or checks and strips block padding on a byte stream
//
// channel   dir  tdata            tuser                      tlast
// s_axis    in   data_byte[7:0]   byte_valid                 end_of_message
// m_axis    out  out_byte[7:0]    out_valid, status[1:0]     out_last
// cfg       in   cfg_data: 0 direction, 1 block_size (no handshake, cfg_we strobe)
//
// bytes pass at one per cycle while idle and the output register is free
// end of message in add mode: an evaluation step, then the pad bytes in order
// end of message in remove mode: an evaluation step, a padding check over the whole block
//   (skipped on a bad length or pad value), then the kept bytes in order or one final result
// stalls hold the emitting steps only; s_axis_tready stays low until the message end is out
// arst_n clears control state only; cell contents are unused until refilled

`include "ansi_x923_padding_unit_assert.svh"

module ansi_x923_padding_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [apu_pkg::CFG_W-1:0]  cfg_data,
	// input stream
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,   // data_byte
	input  logic                       s_axis_tuser,   // byte_valid
	input  logic                       s_axis_tlast,   // end_of_message
	// output stream
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [7:0]                 m_axis_tdata,   // out_byte
	output logic [2:0]                 m_axis_tuser,   // out_valid, status[1:0]
	output logic                       m_axis_tlast    // out_last
);

	localparam int BW = apu_pkg::BLK_W;
	localparam int IW = apu_pkg::IDX_W;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_PAD   = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_FINAL = 3'd5;

	logic [2:0]    state_q, state_d;
	logic          dir_q;
	logic [BW-1:0] bs_q;
	logic [IW-1:0] pos_q, pos_d;
	logic          full_q, full_d;
	logic [BW-1:0] cnt_q, cnt_d;
	// pad count in add mode, kept byte count in remove mode
	logic [BW-1:0] keep_q, keep_d;
	logic          err_q, err_d;
	logic [1:0]    status_q, status_d;

	// output register
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_flag_q;
	logic          out_last_q;
	logic [1:0]    out_status_q;

	logic          out_load;
	logic [7:0]    ob;
	logic          of, ol;
	logic [1:0]    os;

	apu_pkg::chain_ctl_t ctl;
	logic [7:0]    head, tail;
	logic [BW-1:0] bs_m1;
	logic [BW-1:0] pos_inc;
	logic          slot_free;
	logic          accept;

	assign bs_m1     = bs_q - BW'(1);
	assign pos_inc   = {1'b0, pos_q} + BW'(1);
	// the output register takes a new result when empty or emptying this cycle
	assign slot_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && slot_free;
	assign accept    = s_axis_tvalid && s_axis_tready;

	apu_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.in_byte  (s_axis_tdata),
		.tail_idx (bs_m1[IW-1:0]),
		.head     (head),
		.tail     (tail)
	);

	always_comb begin
		state_d      = state_q;
		pos_d        = pos_q;
		full_d       = full_q;
		cnt_d        = cnt_q;
		keep_d       = keep_q;
		err_d        = err_q;
		status_d     = status_q;
		ctl.shift    = 1'b0;
		ctl.load_new = 1'b0;
		out_load     = 1'b0;
		ob           = 8'h00;
		of           = 1'b0;
		ol           = 1'b0;
		os           = apu_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_axis_tuser) begin
						// length bookkeeping, shared by both directions
						if (pos_inc == bs_q) begin
							pos_d  = '0;
							full_d = 1'b1;
						end else begin
							pos_d = pos_inc[IW-1:0];
						end
						if (dir_q == apu_pkg::DIR_ADD) begin
							out_load = 1'b1;
							ob       = s_axis_tdata;
							of       = 1'b1;
						end else begin
							// push into the delay line, oldest byte ages out once full
							ctl.shift    = 1'b1;
							ctl.load_new = 1'b1;
							if (full_q) begin
								out_load = 1'b1;
								ob       = tail;
								of       = 1'b1;
							end
						end
					end
					if (s_axis_tlast) begin
						state_d = S_EVAL;
					end
				end
			end
			S_EVAL: begin
				if (dir_q == apu_pkg::DIR_ADD) begin
					keep_d  = bs_q - {1'b0, pos_q};
					cnt_d   = bs_q - {1'b0, pos_q};
					state_d = S_PAD;
				end else if ((pos_q != '0) || !full_q) begin
					status_d = apu_pkg::ST_BAD_LEN;
					state_d  = S_FINAL;
				end else if (head > {{(8-BW){1'b0}}, bs_q}) begin
					status_d = apu_pkg::ST_BAD_PAD;
					state_d  = S_FINAL;
				end else begin
					keep_d  = bs_q - head[BW-1:0];
					cnt_d   = '0;
					err_d   = 1'b0;
					state_d = S_CHECK;
				end
			end
			S_PAD: begin
				if (slot_free) begin
					out_load = 1'b1;
					of       = 1'b1;
					if (cnt_q == BW'(1)) begin
						ob      = 8'(keep_q);
						ol      = 1'b1;
						pos_d   = '0;
						full_d  = 1'b0;
						state_d = S_IDLE;
					end else begin
						cnt_d = cnt_q - BW'(1);
					end
				end
			end
			S_CHECK: begin
				// one full rotation; pad bytes pass the tail after the kept ones
				ctl.shift = 1'b1;
				if ((cnt_q >= keep_q) && (cnt_q < bs_m1) && (tail != 8'h00)) begin
					err_d = 1'b1;
				end
				if (cnt_q == bs_m1) begin
					cnt_d = '0;
					if (err_q) begin
						status_d = apu_pkg::ST_BAD_PAD;
						state_d  = S_FINAL;
					end else if (keep_q == '0) begin
						status_d = apu_pkg::ST_OK;
						state_d  = S_FINAL;
					end else begin
						state_d = S_EMIT;
					end
				end else begin
					cnt_d = cnt_q + BW'(1);
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					ctl.shift = 1'b1;
					out_load  = 1'b1;
					ob        = tail;
					of        = 1'b1;
					if (cnt_q == keep_q - BW'(1)) begin
						ol      = 1'b1;
						pos_d   = '0;
						full_d  = 1'b0;
						state_d = S_IDLE;
					end else begin
						cnt_d = cnt_q + BW'(1);
					end
				end
			end
			S_FINAL: begin
				if (slot_free) begin
					out_load = 1'b1;
					ol       = 1'b1;
					os       = status_q;
					pos_d    = '0;
					full_d   = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dir_q    <= apu_pkg::DIR_ADD;
			bs_q     <= BW'(16);
			pos_q    <= '0;
			full_q   <= 1'b0;
			cnt_q    <= '0;
			keep_q   <= '0;
			err_q    <= 1'b0;
			status_q <= apu_pkg::ST_OK;
		end else if (cfg_we) begin
			// any register write drops the message in progress
			if (cfg_index == apu_pkg::CFG_DIRECTION) begin
				dir_q <= cfg_data[0];
			end else begin
				bs_q <= apu_pkg::eff_block(cfg_data);
			end
			state_q <= S_IDLE;
			pos_q   <= '0;
			full_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			full_q   <= full_d;
			cnt_q    <= cnt_d;
			keep_q   <= keep_d;
			err_q    <= err_d;
			status_q <= status_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q   <= ob;
			out_flag_q   <= of;
			out_last_q   <= ol;
			out_status_q <= os;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = {out_status_q, out_flag_q};
	assign m_axis_tlast  = out_last_q;

	`APU_ASSERT_IMPLY(a_status_only_last, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser[2:1] != apu_pkg::ST_OK), m_axis_tlast,
		"error status on a non-final result")
	`APU_ASSERT_IMPLY(a_empty_only_last, clk, arst_n,
		m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast,
		"result without a byte before message end")
	`APU_ASSERT_IMPLY(a_check_bound, clk, arst_n,
		state_q == S_CHECK, cnt_q < bs_q,
		"check counter beyond block")
	`APU_ASSERT_IMPLY(a_emit_bound, clk, arst_n,
		state_q == S_EMIT, (keep_q != '0) && (cnt_q < keep_q),
		"emit counter beyond kept bytes")
	`APU_ASSERT_NEXT(a_eval_leaves, clk, arst_n,
		(state_q == S_EVAL) && !cfg_we, (state_q != S_IDLE) && (state_q != S_EVAL),
		"evaluation did not start a message end sequence")

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the ansi x9.23 padding unit
module tb_top;

	// generous end of run, in time units; the clock period is 20 time units
	localparam int RUN_LIMIT = 8000000;
	// cycles to let pass once nothing is expected any more; covers a full
	// remove-mode end of message at the largest block (evaluation, check pass, kept bytes)
	localparam int TAIL_CYCLES = 80;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic [1:0] status;
	} out_beat_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic                      cfg_index = 1'b0;
	logic [apu_pkg::CFG_W-1:0] cfg_data = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [7:0]                s_axis_tdata = 8'h00;   // data_byte
	logic                      s_axis_tuser = 1'b0;    // byte_valid
	logic                      s_axis_tlast = 1'b0;    // end_of_message
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [7:0]                m_axis_tdata;           // out_byte
	logic [2:0]                m_axis_tuser;           // out_valid, status[1:0]
	logic                      m_axis_tlast;           // out_last

	// predicted output transactions, oldest first
	out_beat_t out_beats_q[$];
	// bytes of the message about to be sent
	logic [7:0] msg_buf[$];

	// shadow of the unit: registers and stream state
	logic        dir_q = apu_pkg::DIR_ADD;
	logic [5:0]  bsize_q = 6'd16;
	logic [7:0]  ring [apu_pkg::MAX_BLOCK];
	int          ring_wr = 0;
	int          ring_cnt = 0;
	int          msg_pos = 0;
	bit          msg_full = 1'b0;

	// idling controls shared by the sender, the receiver and the monitor
	bit src_gaps = 1'b0;
	bit sink_gaps = 1'b0;
	int sink_wait = 0;
	int long_hold = 0;

	// run statistics
	int items_taken = 0;
	int beats_seen = 0;
	int msgs_padded = 0;
	int msgs_stripped = 0;
	int mismatch_cnt = 0;

	ansi_x923_padding_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// shadow model of the unit
	// ------------------------------------------------------------------

	// block size as the unit uses it: zero acts as one, large values saturate
	function automatic int active_block();
		int b;
		b = bsize_q;
		if (b == 0) b = 1;
		if (b > apu_pkg::MAX_BLOCK) b = apu_pkg::MAX_BLOCK;
		return b;
	endfunction

	task automatic push_beat(input logic [7:0] d, input logic v, input logic l,
			input logic [1:0] s);
		out_beat_t nb;
		nb.data = d;
		nb.valid = v;
		nb.last = l;
		nb.status = s;
		out_beats_q.push_back(nb);
	endtask

	task automatic clear_ring();
		foreach (ring[i]) ring[i] = 8'h00;
		ring_wr = 0;
		ring_cnt = 0;
		msg_pos = 0;
		msg_full = 1'b0;
	endtask

	task automatic bump_position(input int bs);
		msg_pos++;
		if (msg_pos >= bs) begin
			msg_pos = 0;
			msg_full = 1'b1;
		end
	endtask

	// any register write drops the message in progress
	task automatic cfg_update(input logic idx, input logic [apu_pkg::CFG_W-1:0] val);
		if (idx == apu_pkg::CFG_DIRECTION) begin
			dir_q = val[0];
		end else begin
			bsize_q = val;
		end
		clear_ring();
	endtask

	// expected output transactions caused by one input transaction
	task automatic pad_or_strip(input logic [7:0] b, input logic v, input logic e);
		int bs;
		int w;
		int base;
		int padv;
		int k;
		bit good;
		bs = active_block();
		if (dir_q == apu_pkg::DIR_ADD) begin
			if (v) begin
				push_beat(b, 1'b1, 1'b0, apu_pkg::ST_OK);
				bump_position(bs);
			end
			if (e) begin
				// zeros, then the pad count; an aligned length gets a whole block
				padv = bs - msg_pos;
				for (k = 1; k < padv; k++) push_beat(8'h00, 1'b1, 1'b0, apu_pkg::ST_OK);
				push_beat(8'(padv), 1'b1, 1'b1, apu_pkg::ST_OK);
				clear_ring();
				msgs_padded++;
			end
		end else begin
			if (v) begin
				// the delay line releases its oldest byte once it holds a block
				w = ring_wr % bs;
				if (ring_cnt >= bs) begin
					push_beat(ring[w], 1'b1, 1'b0, apu_pkg::ST_OK);
				end else begin
					ring_cnt++;
				end
				ring[w] = b;
				ring_wr = (w + 1) % bs;
				bump_position(bs);
			end
			if (e) begin
				if (msg_pos != 0 || !msg_full || ring_cnt != bs) begin
					push_beat(8'h00, 1'b0, 1'b1, apu_pkg::ST_BAD_LEN);
				end else begin
					base = ring_wr % bs;
					padv = ring[(base + bs - 1) % bs];
					good = (padv <= bs);
					if (good) begin
						for (k = 1; k < padv; k++) begin
							if (ring[(base + bs - 1 - k) % bs] != 8'h00) good = 1'b0;
						end
					end
					if (!good) begin
						push_beat(8'h00, 1'b0, 1'b1, apu_pkg::ST_BAD_PAD);
					end else if (padv == bs) begin
						// padding filled the whole block, nothing is kept
						push_beat(8'h00, 1'b0, 1'b1, apu_pkg::ST_OK);
					end else begin
						// a pad value of zero keeps the whole block
						for (k = 0; k < bs - padv; k++) begin
							push_beat(ring[(base + k) % bs], 1'b1, (k + 1 == bs - padv),
								apu_pkg::ST_OK);
						end
					end
				end
				clear_ring();
				msgs_stripped++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// monitor: config writes, accepted inputs and checked outputs, in this order
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		out_beat_t got;
		out_beat_t want;
		if (arst_n) begin
			if (cfg_we) cfg_update(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser || s_axis_tlast) items_taken++;
				pad_or_strip(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.data = m_axis_tdata;
				got.valid = m_axis_tuser[0];
				got.status = m_axis_tuser[2:1];
				got.last = m_axis_tlast;
				beats_seen++;
				if (out_beats_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("output %0d: none expected, got %02h %0d %0d %0d",
							beats_seen, got.data, got.valid, got.last, got.status);
				end else begin
					want = out_beats_q.pop_front();
					if (got.data !== want.data || got.valid !== want.valid ||
							got.last !== want.last || got.status !== want.status) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("output %0d: expected byte %02h valid %0d last %0d st %0d",
								beats_seen, want.data, want.valid, want.last, want.status);
							$display("output %0d:      got byte %02h valid %0d last %0d st %0d",
								beats_seen, got.data, got.valid, got.last, got.status);
						end
					end
				end
				// receiver pause before the next transaction
				sink_wait = sink_gaps ? $urandom_range(0, 5) : 0;
			end
		end
	end

	// receiver: long hold first, then the per-transaction pause
	initial begin : sink
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				long_hold--;
				m_axis_tready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers; every task starts and ends at a falling edge
	// ------------------------------------------------------------------

	// one input transaction; tvalid stays high on return so a back-to-back
	// item needs no second assignment in the same step
	task automatic send_item(input logic [7:0] b, input logic v, input logic e);
		int gap;
		gap = src_gaps ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= v;
		s_axis_tlast <= e;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// sends msg_buf with random idle items; end of message on the last byte
	// or on a trailing item without a byte
	task automatic send_msg(input bit split_eom);
		int n;
		n = msg_buf.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(msg_buf[i], 1'b1, (i == n - 1) && !split_eom);
		end
		if (split_eom || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// lower tvalid, wait out every expected transaction and the tail
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (out_beats_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [apu_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic pick_gaps();
		src_gaps = ($urandom_range(0, 3) != 0);
		sink_gaps = ($urandom_range(0, 3) != 0);
	endtask

	// mostly small blocks, sometimes large, now and then zero or above the maximum
	function automatic logic [apu_pkg::CFG_W-1:0] pick_block_raw();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return apu_pkg::CFG_W'($urandom_range(1, 8));
		if (r < 9) return apu_pkg::CFG_W'($urandom_range(9, 32));
		return ($urandom_range(0, 1) == 0) ? apu_pkg::CFG_W'(0) :
			apu_pkg::CFG_W'($urandom_range(33, 63));
	endfunction

	task automatic send_add_msg();
		int bs;
		int len;
		bs = active_block();
		len = $urandom_range(0, (bs <= 8) ? 2 * bs + 1 : bs + 2);
		msg_buf.delete();
		repeat (len) msg_buf.push_back(8'($urandom_range(0, 255)));
		send_msg($urandom_range(0, 3) == 0);
	endtask

	// mostly well-formed padded messages, the rest with broken padding,
	// bad lengths or plain noise
	task automatic send_strip_msg();
		int bs;
		int r;
		int clen;
		int padv;
		int n;
		int k;
		bs = active_block();
		r = $urandom_range(0, 99);
		msg_buf.delete();
		if (r >= 73 && r < 83 && bs >= 2) begin
			// nonzero byte inside the padding
			padv = $urandom_range(2, bs);
			clen = ((bs <= 8) ? $urandom_range(0, 1) * bs : 0) + (bs - padv);
			repeat (clen) msg_buf.push_back(8'($urandom_range(0, 255)));
			repeat (padv - 1) msg_buf.push_back(8'h00);
			msg_buf.push_back(8'(padv));
			k = msg_buf.size() - 1 - $urandom_range(1, padv - 1);
			msg_buf[k] = 8'($urandom_range(1, 255));
		end else if (r >= 55 && r < 65) begin
			// pad value zero keeps every byte
			n = $urandom_range(1, (bs <= 8) ? 2 : 1) * bs;
			repeat (n - 1) msg_buf.push_back(8'($urandom_range(0, 255)));
			msg_buf.push_back(8'h00);
		end else if (r >= 83 && r < 93) begin
			// length zero or not a whole number of blocks
			n = $urandom_range(0, (bs <= 8) ? 3 * bs : bs + 2);
			if (bs == 1) n = 0;
			else if (n % bs == 0 && n != 0) n++;
			repeat (n) msg_buf.push_back(8'($urandom_range(0, 255)));
		end else if (r >= 93) begin
			n = $urandom_range(0, 2 * bs);
			repeat (n) msg_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			// proper padding; pad value above the block size in one band
			clen = $urandom_range(0, (bs <= 8) ? 2 * bs : bs);
			padv = bs - (clen % bs);
			repeat (clen) msg_buf.push_back(8'($urandom_range(0, 255)));
			repeat (padv - 1) msg_buf.push_back(8'h00);
			msg_buf.push_back(8'(padv));
			if (r >= 65) msg_buf[msg_buf.size() - 1] = 8'($urandom_range(bs + 1, 255));
		end
		send_msg($urandom_range(0, 3) == 0);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// add mode with block 4: empty message, one byte, aligned length, then an
	// unfinished message that the next register write drops
	task automatic test_add_directed();
		write_reg(apu_pkg::CFG_DIRECTION, {5'b0, apu_pkg::DIR_ADD});
		write_reg(apu_pkg::CFG_BLOCK_SIZE, apu_pkg::CFG_W'(4));
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		send_item(8'h5A, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h3C, 1'b0, 1'b0);
		msg_buf = '{8'h00, 8'hFF, 8'hAA, 8'h55};
		send_msg(1'b0);
		send_item(8'h81, 1'b1, 1'b0);
		send_item(8'h7E, 1'b1, 1'b0);
		settle();
	endtask

	// remove mode with block 2: each verdict at least once, then an unfinished message
	task automatic test_strip_directed();
		write_reg(apu_pkg::CFG_DIRECTION, {5'b0, apu_pkg::DIR_REMOVE});
		write_reg(apu_pkg::CFG_BLOCK_SIZE, apu_pkg::CFG_W'(2));
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		msg_buf = '{8'hAB, 8'h01};
		send_msg(1'b0);
		// pad value zero
		msg_buf = '{8'h5A, 8'h00};
		send_msg(1'b0);
		// padding fills the block
		msg_buf = '{8'h00, 8'h02};
		send_msg(1'b0);
		// pad value above the block size
		msg_buf = '{8'h11, 8'h03};
		send_msg(1'b0);
		// nonzero pad byte
		msg_buf = '{8'h07, 8'h02};
		send_msg(1'b0);
		// empty and odd length
		send_item(8'hE1, 1'b0, 1'b1);
		msg_buf = '{8'h01, 8'h02, 8'h03};
		send_msg(1'b0);
		send_item(8'hC3, 1'b1, 1'b0);
		send_item(8'h3C, 1'b1, 1'b0);
		send_item(8'h99, 1'b1, 1'b0);
		settle();
	endtask

	task automatic test_add_random();
		int stop_at;
		for (int ph = 0; ph < 3; ph++) begin
			settle();
			write_reg(apu_pkg::CFG_DIRECTION,
				{5'($urandom_range(0, 31)), apu_pkg::DIR_ADD});
			write_reg(apu_pkg::CFG_BLOCK_SIZE, pick_block_raw());
			stop_at = items_taken + 5;
			while (items_taken < stop_at) begin
				pick_gaps();
				send_add_msg();
			end
		end
		settle();
	endtask

	task automatic test_strip_random();
		int stop_at;
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_reg(apu_pkg::CFG_DIRECTION,
				{5'($urandom_range(0, 31)), apu_pkg::DIR_REMOVE});
			write_reg(apu_pkg::CFG_BLOCK_SIZE, pick_block_raw());
			stop_at = items_taken + 5;
			while (items_taken < stop_at) begin
				pick_gaps();
				send_strip_msg();
			end
		end
		settle();
	endtask

	// zero and above-maximum block settings next to the real extremes
	task automatic test_block_limits();
		logic [apu_pkg::CFG_W-1:0] raw_sizes [4];
		raw_sizes = '{apu_pkg::CFG_W'(0), apu_pkg::CFG_W'(63), apu_pkg::CFG_W'(32),
			apu_pkg::CFG_W'(1)};
		foreach (raw_sizes[i]) begin
			settle();
			write_reg(apu_pkg::CFG_BLOCK_SIZE, raw_sizes[i]);
			write_reg(apu_pkg::CFG_DIRECTION, {5'b0, apu_pkg::DIR_REMOVE});
			pick_gaps();
			send_strip_msg();
			if (active_block() < apu_pkg::MAX_BLOCK) begin
				pick_gaps();
				send_strip_msg();
			end
			settle();
			write_reg(apu_pkg::CFG_DIRECTION, {5'b0, apu_pkg::DIR_ADD});
			write_reg(apu_pkg::CFG_BLOCK_SIZE, raw_sizes[i]);
			pick_gaps();
			send_add_msg();
			if (raw_sizes[i] < 2) begin
				pick_gaps();
				send_add_msg();
			end
		end
		settle();
	endtask

	// receiver stalls for a long stretch while the sender keeps going, so
	// the unit fills up and drops s_axis_tready
	task automatic test_output_backpressure();
		write_reg(apu_pkg::CFG_DIRECTION, {5'b0, apu_pkg::DIR_ADD});
		write_reg(apu_pkg::CFG_BLOCK_SIZE, apu_pkg::CFG_W'(8));
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		@(posedge clk);
		long_hold = 200;
		@(negedge clk);
		msg_buf.delete();
		repeat (24) msg_buf.push_back(8'($urandom_range(0, 255)));
		send_msg(1'b0);
		settle();
		write_reg(apu_pkg::CFG_DIRECTION, {5'b0, apu_pkg::DIR_REMOVE});
		@(posedge clk);
		long_hold = 150;
		@(negedge clk);
		send_strip_msg();
		send_strip_msg();
		settle();
	endtask

	initial begin : run
		// reset held low, then released at a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_add_directed();
		test_strip_directed();
		test_add_random();
		test_strip_random();
		test_block_limits();
		test_output_backpressure();
		settle();
		if (out_beats_q.size() != 0) begin
			$display("%0d expected output transactions never arrived", out_beats_q.size());
			mismatch_cnt += out_beats_q.size();
		end
		$display("%0d input transactions with data or end of message, %0d outputs checked",
			items_taken, beats_seen);
		$display("%0d messages padded, %0d messages checked and stripped, %0d mismatches",
			msgs_padded, msgs_stripped, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("ansi_x923_padding_unit: match");
		end else begin
			$display("ansi_x923_padding_unit: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("ansi_x923_padding_unit: mismatch");
		$finish;
	end

endmodule
